// ----- src/slu_pkg.sv -----
package slu_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_VALID   = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_DECODE = 3'b001,
    PH_TAIL   = 3'b010,
    PH_BAD    = 3'b100
  } phase_t;

  localparam int unsigned ACC_W       = 48;
  localparam int unsigned HELD_W      = 6;
  localparam int unsigned TAIL_W      = 7;
  localparam int unsigned HDR_BITS    = 10;
  localparam int unsigned HELD_CLAMP  = 40;
  localparam int unsigned TAIL_LIMIT  = 64;
  localparam int unsigned TAIL_SAT    = 127;
  localparam int unsigned PREFIX_W    = 31;

  typedef struct packed {
    kind_t                kind;
    logic [4:0]           prefix_length;
    logic [4:0]           label_bits;
    logic [PREFIX_W-1:0]  prefix_value;
    logic                 end_of_run;
  } result_t;

endpackage

// ----- src/slu_decode.sv -----
module slu_decode import slu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] byte_in,
  input  logic       final_byte,
  output logic       rec_valid,
  output result_t    rec_res,
  output logic       stat_valid,
  output result_t    stat_res
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  phase_t            phase_r, phase_nxt;

  logic [HELD_W-1:0]   held_c;
  logic [HELD_W-1:0]   held_sum;
  logic [HELD_W-1:0]   need;
  logic [ACC_W-1:0]    acc_in;
  logic [4:0]          plen;
  logic [4:0]          cnt;
  logic [PREFIX_W-1:0] prefix;
  logic [TAIL_W:0]     tail_sum;
  logic                ok;

  always_comb begin
    held_c   = (held_r > HELD_W'(HELD_CLAMP)) ? HELD_W'(HELD_CLAMP) : held_r;
    acc_in   = acc_r | (ACC_W'(byte_in) << held_c);
    held_sum = held_c + HELD_W'(8);
    plen     = acc_in[4:0];
    cnt      = acc_in[9:5];
    need     = HELD_W'(HDR_BITS) + HELD_W'(plen);
    prefix   = PREFIX_W'(acc_in >> HDR_BITS) & ~({PREFIX_W{1'b1}} << plen);
    tail_sum = {1'b0, tail_r} + (TAIL_W+1)'(8);

    acc_nxt   = acc_r;
    held_nxt  = held_r;
    tail_nxt  = tail_r;
    phase_nxt = phase_r;
    rec_valid = 1'b0;

    case (phase_r)
      PH_DECODE: begin
        acc_nxt  = acc_in;
        held_nxt = held_sum;
        if (held_sum >= HELD_W'(HDR_BITS)) begin
          if (cnt == 5'd0) begin
            // Terminator: everything held so far must be zero.
            phase_nxt = (acc_in != '0) ? PH_BAD : PH_TAIL;
            tail_nxt  = TAIL_W'(held_sum);
            acc_nxt   = '0;
            held_nxt  = '0;
          end else if (held_sum >= need) begin
            rec_valid = 1'b1;
            acc_nxt   = acc_in >> need;
            held_nxt  = held_sum - need;
          end
        end
      end
      PH_TAIL: begin
        tail_nxt = (tail_sum > (TAIL_W+1)'(TAIL_SAT)) ? TAIL_W'(TAIL_SAT)
                                                      : tail_sum[TAIL_W-1:0];
        if (byte_in != 8'd0 || tail_nxt >= TAIL_W'(TAIL_LIMIT)) begin
          phase_nxt = PH_BAD;
        end
      end
      default: begin
      end
    endcase

    case (phase_nxt)
      PH_DECODE: ok = (acc_nxt == '0);
      PH_TAIL:   ok = (tail_nxt < TAIL_W'(TAIL_LIMIT));
      default:   ok = 1'b0;
    endcase

    stat_valid = final_byte;

    rec_res.kind          = KIND_RECORD;
    rec_res.prefix_length = plen;
    rec_res.label_bits    = cnt;
    rec_res.prefix_value  = prefix;
    rec_res.end_of_run    = ~final_byte;

    stat_res.kind          = ok ? KIND_VALID : KIND_INVALID;
    stat_res.prefix_length = '0;
    stat_res.label_bits    = '0;
    stat_res.prefix_value  = '0;
    stat_res.end_of_run    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      held_r  <= '0;
      tail_r  <= '0;
      phase_r <= PH_DECODE;
    end else if (take) begin
      if (final_byte) begin
        acc_r   <= '0;
        held_r  <= '0;
        tail_r  <= '0;
        phase_r <= PH_DECODE;
      end else begin
        acc_r   <= acc_nxt;
        held_r  <= held_nxt;
        tail_r  <= tail_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

endmodule

// ----- src/scheme_list_bit_unpacker.sv -----
// Channel  | Direction | Ports                                             | Handshake
// ---------+-----------+---------------------------------------------------+---------------------
// input    | in        | in_byte_in[7:0], in_final_byte                    | in_valid / in_ready
// result   | out       | out_kind, out_prefix_length, out_label_bits,      | out_valid / out_ready
//          |           | out_prefix_value, out_end_of_run                  |
//
// Each byte is decoded in the cycle it is accepted and its results appear from
// the next cycle. A byte yields at most two results (a record and a status),
// held in a two-entry result register, so one byte per cycle is taken while
// each byte yields at most one result and out_ready stays high. Reset (rst_n
// low, synchronous) clears the decoder state and empties the result register.
// A stalled result side holds off the input once the register cannot drain.
module scheme_list_bit_unpacker import slu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte_in,
  input  logic                in_final_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [4:0]          out_prefix_length,
  output logic [4:0]          out_label_bits,
  output logic [PREFIX_W-1:0] out_prefix_value,
  output logic                out_end_of_run
);

  logic    take;
  logic    rec_valid;
  logic    stat_valid;
  result_t rec_res;
  result_t stat_res;

  // Result register: slot0 is presented, slot1 holds a status waiting behind
  // a record from the same byte.
  result_t    slot0_r, slot1_r;
  logic [1:0] count_r;

  // A new item is taken when the result register is empty, or will be after
  // the single result it holds is taken this cycle.
  assign in_ready = (count_r == 2'd0) || (count_r == 2'd1 && out_ready);
  assign take     = in_valid && in_ready;

  slu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .byte_in    (in_byte_in),
    .final_byte (in_final_byte),
    .rec_valid  (rec_valid),
    .rec_res    (rec_res),
    .stat_valid (stat_valid),
    .stat_res   (stat_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (take) begin
      count_r <= 2'(rec_valid) + 2'(stat_valid);
    end else if (out_valid && out_ready) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0_r <= rec_valid ? rec_res : stat_res;
      slot1_r <= stat_res;
    end else if (out_valid && out_ready) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_valid         = (count_r != 2'd0);
  assign out_kind          = slot0_r.kind;
  assign out_prefix_length = slot0_r.prefix_length;
  assign out_label_bits    = slot0_r.label_bits;
  assign out_prefix_value  = slot0_r.prefix_value;
  assign out_end_of_run    = slot0_r.end_of_run;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

import slu_pkg::*;

// Tracks the decoder state for every accepted byte and holds the results that
// the block owes, oldest first.
class record_scoreboard;
  result_t          expected_q[$];
  int               errors;
  logic [ACC_W-1:0] acc;
  int               held;
  phase_t           ph;
  int               tail_bits;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    acc       = '0;
    held      = 0;
    ph        = PH_DECODE;
    tail_bits = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Decodes one accepted byte and queues the records and status it yields.
  function void note_byte(input logic [7:0] b, input logic fin);
    result_t    r;
    logic [4:0] plen;
    logic [4:0] cnt;
    int         n_before;
    logic       ok;
    n_before = expected_q.size();
    if (ph == PH_DECODE) begin
      if (held > HELD_CLAMP) held = HELD_CLAMP;
      acc = acc | (ACC_W'(b) << held);
      held += 8;
      if (held >= HDR_BITS) begin
        plen = acc[4:0];
        cnt  = acc[9:5];
        if (cnt == 5'd0) begin
          // A terminator: everything held from its first bit must be zero.
          ph        = (acc != '0) ? PH_BAD : PH_TAIL;
          tail_bits = held;
          acc       = '0;
          held      = 0;
        end else if (held >= HDR_BITS + plen) begin
          r               = '0;
          r.kind          = KIND_RECORD;
          r.prefix_length = plen;
          r.label_bits    = cnt;
          r.prefix_value  = PREFIX_W'((acc >> HDR_BITS) & ((ACC_W'(1) << plen) - 1));
          expected_q.push_back(r);
          acc  = acc >> (HDR_BITS + plen);
          held = held - int'(HDR_BITS) - int'(plen);
        end
      end
    end else if (ph == PH_TAIL) begin
      tail_bits = (tail_bits + 8 > TAIL_SAT) ? TAIL_SAT : tail_bits + 8;
      if (b != 8'd0 || tail_bits >= TAIL_LIMIT) ph = PH_BAD;
    end
    if (fin) begin
      case (ph)
        PH_DECODE: ok = (acc == '0);
        PH_TAIL:   ok = (tail_bits < TAIL_LIMIT);
        default:   ok = 1'b0;
      endcase
      r      = '0;
      r.kind = ok ? KIND_VALID : KIND_INVALID;
      expected_q.push_back(r);
      clear_state();
    end
    if (expected_q.size() > n_before) expected_q[$].end_of_run = 1'b1;
  endfunction

  function void compare_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
      errors++;
    end
  endfunction

  function void check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d length %0d bits %0d",
               $time, got.kind, got.prefix_length, got.label_bits);
      errors++;
    end else begin
      want = expected_q.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("prefix_length", 32'(want.prefix_length), 32'(got.prefix_length));
      compare_field("label_bits", 32'(want.label_bits), 32'(got.label_bits));
      compare_field("prefix_value", 32'(want.prefix_value), 32'(got.prefix_value));
      compare_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
    end
  endfunction
endclass

module testbench;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_byte_in;
  logic                in_final_byte;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_kind;
  logic [4:0]          out_prefix_length;
  logic [4:0]          out_label_bits;
  logic [PREFIX_W-1:0] out_prefix_value;
  logic                out_end_of_run;

  record_scoreboard sb = new();

  // The stream under construction, oldest bit first, before it is cut into bytes.
  bit bits_q[$];
  int burst_left;
  int bytes_sent;
  // Set by the stimulus, cleared by the result side once it has started a hold-off.
  bit hold_off_req;

  scheme_list_bit_unpacker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_prefix_length (out_prefix_length),
    .out_label_bits    (out_label_bits),
    .out_prefix_value  (out_prefix_value),
    .out_end_of_run    (out_end_of_run)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hard ceiling on the run. A correct run is far shorter, even with every
  // byte waiting out the slowest stall pattern on the result side.
  initial begin : watchdog
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Both channels are sampled at the rising edge. The result is checked before
  // the byte of the same edge is noted, so a result that no earlier byte owed
  // can never be matched against the predictions of the byte just taken.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind          = kind_t'(out_kind);
        got.prefix_length = out_prefix_length;
        got.label_bits    = out_label_bits;
        got.prefix_value  = out_prefix_value;
        got.end_of_run    = out_end_of_run;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_byte(in_byte_in, in_final_byte);
    end
  end

  // The result side runs through modes of its own: always ready, or stalling
  // at one of several rates. On request it holds off for a long stretch so
  // that the result register fills and the block has to stall its input.
  initial begin : result_side
    int mode_left;
    int stall_pct;
    int hold_left;
    out_ready = 1'b0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = $urandom_range(60, 120);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offers one byte and waits until it is taken. The sender works in bursts;
  // at the start of each burst it may leave a gap with valid low.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_byte_in    <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stops sending and waits until every owed result has come out, then idles before going on.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic void put_bits(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) bits_q.push_back(v[i]);
  endfunction

  function automatic void put_record(input int plen, input int cnt, input logic [31:0] prefix);
    put_bits(plen, 5);
    put_bits(cnt, 5);
    put_bits(prefix, plen);
  endfunction

  // Prefix lengths lean towards the short ones and the longest one.
  function automatic void put_random_record();
    int plen;
    case ($urandom_range(0, 7))
      0, 1:    plen = $urandom_range(0, 3);
      2:       plen = 31;
      default: plen = $urandom_range(0, 31);
    endcase
    put_record(plen, $urandom_range(1, 31), $urandom());
  endfunction

  // Pads the stream with zeros to whole bytes and sends it, the last byte
  // marked final. An empty stream still needs one byte to carry the mark.
  task automatic send_stream();
    logic [7:0] b;
    int         n_bytes;
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
    if (bits_q.size() == 0) put_bits(0, 8);
    n_bytes = bits_q.size() / 8;
    for (int i = 0; i < n_bytes; i++) begin
      for (int j = 0; j < 8; j++) b[j] = bits_q[8 * i + j];
      send_byte(b, i == n_bytes - 1);
    end
    bits_q.delete();
  endtask

  // One random stream. Most are well formed with random content, so that the
  // decoder gets through records into the terminator and its tail; the rest
  // are cut short, corrupted, or plain noise.
  task automatic random_stream();
    int shape;
    int idx;
    int cut;
    shape = $urandom_range(0, 99);
    repeat ($urandom_range(0, 6)) put_random_record();
    if (shape < 45) begin
      // Explicit terminator, then a zero tail that now and then runs too long.
      put_bits(0, 10);
      while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
      put_bits(0, 8 * (($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
                                                   : $urandom_range(0, 3)));
    end else if (shape < 60) begin
      // No terminator: the stream ends on zero padding alone.
    end else if (shape < 70) begin
      // The last record is cut off by the end of the stream.
      if (bits_q.size() > 0) begin
        cut = $urandom_range(1, (bits_q.size() < 20) ? bits_q.size() : 20);
        repeat (cut) void'(bits_q.pop_back());
      end
    end else if (shape < 78) begin
      // One flipped bit somewhere in an otherwise good stream.
      put_bits(0, 10);
      idx = $urandom_range(0, bits_q.size() - 1);
      bits_q[idx] = ~bits_q[idx];
    end else if (shape < 86) begin
      if ($urandom_range(0, 1)) begin
        // A terminator whose prefix length is not zero, then bytes to be ignored.
        put_bits($urandom_range(1, 31), 5);
        put_bits(0, 5);
        put_bits($urandom(), $urandom_range(0, 24));
      end else begin
        // A nonzero byte inside the tail.
        put_bits(0, 10);
        while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
        put_bits(0, 8 * $urandom_range(0, 2));
        put_bits($urandom_range(1, 255), 8);
      end
    end else begin
      bits_q.delete();
      repeat ($urandom_range(1, 8)) put_bits($urandom(), 8);
    end
    send_stream();
  endtask

  initial begin : stimulus
    int next_hold_at;
    int next_drain_at;
    in_valid      = 1'b0;
    in_byte_in    = 8'd0;
    in_final_byte = 1'b0;
    rst_n         = 1'b0;
    burst_left    = 0;
    bytes_sent    = 0;
    hold_off_req  = 1'b0;
    next_hold_at  = 300;
    next_drain_at = 150;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A record with no prefix, then the longest record with every prefix bit
    // set, then the terminator.
    put_record(0, 1, 0);
    put_record(31, 31, 32'h7fff_ffff);
    put_bits(0, 10);
    send_stream();

    // A terminator with a nonzero prefix length; the ones after it are ignored.
    put_bits(9, 5);
    put_bits(0, 5);
    put_bits(32'hffff, 16);
    send_stream();

    // A tail of exactly 64 bits from the terminator's first bit is too long.
    put_bits(0, 64);
    send_stream();

    // A record cut off by the end of the stream.
    put_bits(20, 5);
    put_bits(3, 5);
    put_bits(6'h3f, 6);
    send_stream();

    // A nonzero byte after the terminator.
    put_bits(0, 10);
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
    put_bits(8'h80, 8);
    send_stream();

    // Single-byte streams: all zero is a valid empty list, all ones is cut off.
    put_bits(8'h00, 8);
    send_stream();
    put_bits(8'hff, 8);
    send_stream();
    drain();

    while (bytes_sent < 1900) begin
      if (bytes_sent >= next_hold_at) begin
        // Many short records while the result side holds off, so that results
        // pile up and the input has to stall.
        next_hold_at += 700;
        hold_off_req = 1'b1;
        repeat (30) put_record($urandom_range(0, 4), $urandom_range(1, 31), $urandom());
        put_bits(0, 10);
        send_stream();
      end
      if (bytes_sent >= next_drain_at) begin
        next_drain_at += 400;
        drain();
      end
      random_stream();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Results come out from the cycle after their byte; a short wait catches
    // any stray result that should not be there.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/slu_pkg.sv
src/slu_decode.sv
src/scheme_list_bit_unpacker.sv
tb/sv/testbench.sv
